/* hdl/wpm_pkg.sv */
// Package for the wildcard pattern matcher: operation codes, wildcard bytes, defaults.
package wpm_pkg;

  // Kind of input word, carried on the slave-side tuser
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  localparam int unsigned PATTERN_LEN_DEF = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned OUT_TDATA_W     = 8;

  localparam logic [BYTE_W-1:0] CH_ANY = 8'h3F;  // '?'
  localparam logic [BYTE_W-1:0] CH_RUN = 8'h2A;  // '*'

endpackage

/* hdl/wildcard_pattern_matcher.sv */
// Glob-style whole-string matcher, bit-parallel over all pattern positions.
//
//  channel  | dir | handshake                    | word contents
//  ---------+-----+------------------------------+--------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser[1:0] operation, tdata[7:0] byte
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[0] matched, tdata[1] overflow
//
//  One word per cycle unless an end-of-text word stalls: a word is registered at the input, then one pass of
//  logic (star closure as a log-depth prefix, then a parallel step over every
//  position) updates the state and, for end of text, loads the result register.
//  An end-of-text word passes through the input register and then the result register.
//  Reset clears the active set to position zero, the pattern length and overflow.
//  Only end-of-text words wait on m_axis_tready; while a result is held and not
//  taken, one further end-of-text word stalls in the input register.
module wildcard_pattern_matcher #(
  parameter int unsigned PATTERN_LEN = wpm_pkg::PATTERN_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [wpm_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]                      s_axis_tuser,   // [1:0] operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [wpm_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [0] matched, [1] overflow, zeros
);
  import wpm_pkg::*;

  localparam int unsigned N      = PATTERN_LEN;
  localparam int unsigned LEVELS = $clog2(N + 1);

  // ---------------------------------------------------------------- input register
  logic              in_valid_q, in_valid_d;
  op_e               in_op_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              m_valid_q, m_valid_d;

  logic s_accept, out_free, consume;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign consume       = in_valid_q && ((in_op_q != OP_END) || out_free);
  assign s_axis_tready = !in_valid_q || consume;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- pattern store
  // used_q is a thermometer: bit p set when entry p holds a pattern byte.
  logic [BYTE_W-1:0] pat_q [N];
  logic [N-1:0]      used_q, used_d;
  logic [N:0]        used_sh;      // bit p: entry p-1 used (bit 0 always)
  logic [N-1:0]      wr_slot;      // first free entry
  logic [N-1:0]      is_star, is_hit;

  assign used_sh = {used_q, 1'b1};
  assign wr_slot = used_sh[N-1:0] & ~used_q;

  always_comb begin
    for (int p = 0; p < N; p++) begin
      is_star[p] = used_q[p] && (pat_q[p] == CH_RUN);
      is_hit[p]  = used_q[p] && (pat_q[p] != CH_RUN) &&
                   ((pat_q[p] == CH_ANY) || (pat_q[p] == in_byte_q));
    end
  end

  // ---------------------------------------------------------------- star closure
  // closed[i] |= closed[i-1] & star[i-1], done as a Kogge-Stone prefix.
  logic [N:0] active_q, active_d;
  logic [N:0] gen_l  [LEVELS+1];
  logic [N:0] prop_l [LEVELS+1];
  logic [N:0] closed;

  always_comb begin
    gen_l[0]  = active_q;
    prop_l[0] = {is_star, 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i <= N; i++) begin
        if (i >= (1 << l)) begin
          gen_l[l+1][i]  = gen_l[l][i] | (prop_l[l][i] & gen_l[l][i - (1 << l)]);
          prop_l[l+1][i] = prop_l[l][i] & prop_l[l][i - (1 << l)];
        end else begin
          gen_l[l+1][i]  = gen_l[l][i];
          prop_l[l+1][i] = 1'b0;
        end
      end
    end
    closed = gen_l[LEVELS];
  end

  // ---------------------------------------------------------------- text step
  logic [N:0] step_set;
  logic [N:0] end_mask;   // position equal to the pattern length
  logic       hit;

  assign step_set = {1'b0, closed[N-1:0] & is_star} | {closed[N-1:0] & is_hit, 1'b0};
  assign end_mask = used_sh & ~{1'b0, used_q};
  assign hit      = |(closed & end_mask);

  // ---------------------------------------------------------------- state update
  logic overflow_q, overflow_d;
  logic res_matched_q, res_ovf_q;
  logic load_res;

  assign load_res = consume && (in_op_q == OP_END);

  always_comb begin
    used_d     = used_q;
    active_d   = active_q;
    overflow_d = overflow_q;
    if (consume) begin
      unique case (in_op_q)
        OP_CLEAR: begin
          used_d     = '0;
          overflow_d = 1'b0;
          active_d   = (N + 1)'(1);
        end
        OP_APPEND: begin
          if (used_q[N-1]) begin
            overflow_d = 1'b1;   // store full, byte dropped
          end else begin
            used_d = used_q | wr_slot;
          end
          active_d = (N + 1)'(1);
        end
        OP_TEXT: begin
          active_d = step_set;
        end
        OP_END: begin
          active_d = (N + 1)'(1);
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_res) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      used_q     <= '0;
      active_q   <= (N + 1)'(1);
      overflow_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      used_q     <= used_d;
      active_q   <= active_d;
      overflow_q <= overflow_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata;
    end
    if (load_res) begin
      res_matched_q <= hit && !overflow_q;
      res_ovf_q     <= overflow_q;
    end
    for (int p = 0; p < N; p++) begin
      if (consume && (in_op_q == OP_APPEND) && wr_slot[p]) begin
        pat_q[p] <= in_byte_q;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, res_ovf_q, res_matched_q};

  // ---------------------------------------------------------------- assertions
  a_used_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used_q >> 1) & ~used_q) == '0)
    else $error("pattern store fill mask has a gap");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> used_q[N-1])
    else $error("overflow set with store not full");

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~used_sh) == '0)
    else $error("active position beyond pattern length");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> m_valid_q)
    else $error("end of text consumed without a result");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(m_axis_tdata)))
    else $error("held result lost or changed");

endmodule

/* sim/wpm_match_checker.sv */
// Checker for the wildcard pattern matcher: tracks pattern and reach set, compares verdicts.
`timescale 1ns / 1ps

module wpm_match_checker #(
  parameter int unsigned PATTERN_LEN = wpm_pkg::PATTERN_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [wpm_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]                      s_axis_tuser,   // [1:0] operation
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [wpm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [0] matched, [1] overflow, zeros
  output int unsigned                     errors_o,
  output int unsigned                     pending_o
);
  import wpm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [BYTE_W-1:0]                  glob_mem [PATTERN_LEN];
  logic [$clog2(PATTERN_LEN+1)-1:0]   glob_len;
  logic [PATTERN_LEN:0]               reach;      // held before star closure
  logic                               glob_ovf;
  int unsigned                        errors;

  // A star at a reachable position also makes the next one reachable, chained.
  function automatic logic [PATTERN_LEN:0] star_close(input logic [PATTERN_LEN:0] set);
    for (int p = 0; p < glob_len; p++) begin
      if (set[p] && glob_mem[p] == CH_RUN) set[p+1] = 1'b1;
    end
    return set;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [PATTERN_LEN:0] closed, nxt;
    verdict_t             want;
    op_e                  op;
    if (!rst_ni) begin
      glob_len = '0;
      glob_ovf = 1'b0;
      reach    = {{PATTERN_LEN{1'b0}}, 1'b1};
      errors   = 0;
      verdict_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // results first: a word accepted this edge cannot produce one yet
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result word tdata=%h", m_axis_tdata);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.matched) begin
            $error("matched: expected %b, got %b", want.matched, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[1] !== want.overflow) begin
            $error("pattern_overflow: expected %b, got %b", want.overflow, m_axis_tdata[1]);
            errors++;
          end
          if (m_axis_tdata[OUT_TDATA_W-1:2] !== '0) begin
            $error("tdata padding: expected 0, got %h", m_axis_tdata[OUT_TDATA_W-1:2]);
            errors++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        op = op_e'(s_axis_tuser);
        case (op)
          OP_CLEAR: begin
            glob_len = '0;
            glob_ovf = 1'b0;
            reach    = {{PATTERN_LEN{1'b0}}, 1'b1};
          end
          OP_APPEND: begin
            if (glob_len < PATTERN_LEN) begin
              glob_mem[glob_len[$clog2(PATTERN_LEN)-1:0]] = s_axis_tdata;
              glob_len++;
            end else begin
              glob_ovf = 1'b1;  // byte dropped, sticky until clear
            end
            reach = {{PATTERN_LEN{1'b0}}, 1'b1};  // abandons any text in progress
          end
          OP_TEXT: begin
            closed = star_close(reach);
            nxt    = '0;
            for (int p = 0; p < glob_len; p++) begin
              if (closed[p]) begin
                if (glob_mem[p] == CH_RUN) nxt[p] = 1'b1;
                else if (glob_mem[p] == CH_ANY || glob_mem[p] == s_axis_tdata) nxt[p+1] = 1'b1;
              end
            end
            reach = nxt;
          end
          default: begin  // OP_END
            closed        = star_close(reach);
            want.matched  = closed[glob_len] && !glob_ovf;
            want.overflow = glob_ovf;
            verdict_q.insert(verdict_q.size(), want);
            reach = {{PATTERN_LEN{1'b0}}, 1'b1};
          end
        endcase
      end

      errors_o  <= errors;
      pending_o <= verdict_q.size();
    end
  end

endmodule

/* sim/wildcard_pattern_matcher_test.sv */
// Testbench top for the wildcard pattern matcher: clock, reset, word traffic and verdict.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_test;
  import wpm_pkg::*;

  localparam logic [BYTE_W-1:0] CH_A = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CH_B = 8'h62;  // 'b'
  localparam int unsigned WORD_TARGET = 1400;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned verdicts_owed;
  int unsigned words_sent;
  bit          calm;  // no source gaps while set

  wildcard_pattern_matcher i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  wpm_match_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .errors_o  (fail_count),
    .pending_o (verdicts_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [BYTE_W-1:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_A;
    if (r < 85) return CH_B;
    if (r < 92) return CH_RUN;  // literal star in text
    if (r < 95) return CH_ANY;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] glob_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CH_RUN;
    if (r < 40) return CH_ANY;
    if (r < 65) return CH_A;
    if (r < 90) return CH_B;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // one word on the slave side; valid stays up across back-to-back words
  task automatic send_word(input op_e op, input logic [BYTE_W-1:0] value);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // clear, load a pattern, then run a few texts against it
  task automatic glob_session();
    logic [BYTE_W-1:0] glob_q[$];
    logic [BYTE_W-1:0] text_q[$];
    int                glob_n;
    int                idx;
    calm   = ($urandom_range(0, 4) == 0);
    glob_n = ($urandom_range(0, 99) < 8) ? $urandom_range(PATTERN_LEN_DEF - 2, PATTERN_LEN_DEF + 2)
                                         : $urandom_range(0, 8);
    send_word(OP_CLEAR, BYTE_W'($urandom_range(0, 255)));
    repeat (glob_n) begin
      glob_q.insert(glob_q.size(), glob_byte());
      send_word(OP_APPEND, glob_q[$]);
    end
    repeat ($urandom_range(1, 4)) begin
      text_q.delete();
      if ($urandom_range(0, 99) < 70) begin
        // text built to fit the pattern, sometimes damaged
        foreach (glob_q[i]) begin
          if (glob_q[i] == CH_RUN) begin
            repeat ($urandom_range(0, 3)) text_q.insert(text_q.size(), text_byte());
          end
          else if (glob_q[i] == CH_ANY) text_q.insert(text_q.size(), text_byte());
          else text_q.insert(text_q.size(), glob_q[i]);
        end
        if ($urandom_range(0, 99) < 30) begin
          if (text_q.size() == 0) text_q.insert(0, text_byte());
          else begin
            idx = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 2))
              0: text_q[idx] = text_byte();
              1: text_q.delete(idx);
              default: text_q.insert(idx, text_byte());
            endcase
          end
        end
      end else begin
        repeat ($urandom_range(0, 6)) text_q.insert(text_q.size(), text_byte());
      end
      foreach (text_q[i]) send_word(OP_TEXT, text_q[i]);
      send_word(OP_END, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // any operation in any order, appends mid-text among them
  task automatic noise_burst();
    calm = 1'b0;
    repeat ($urandom_range(3, 10)) begin
      send_word(op_e'($urandom_range(0, 3)), text_byte());
    end
  endtask

  // result side: random stalls, mostly short, with long ready stretches too
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CLEAR;
    calm          = 1'b0;
    words_sent    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pattern with empty text matches
    send_word(OP_END, 8'h00);
    // extreme byte values as literals
    send_word(OP_APPEND, 8'h00);
    send_word(OP_APPEND, 8'hFF);
    send_word(OP_TEXT, 8'h00);
    send_word(OP_TEXT, 8'hFF);
    send_word(OP_END, 8'hFF);
    // a star in the pattern swallows literal stars in the text
    send_word(OP_CLEAR, 8'hA5);
    send_word(OP_APPEND, CH_RUN);
    send_word(OP_TEXT, CH_RUN);
    send_word(OP_TEXT, CH_RUN);
    send_word(OP_END, 8'h5A);
    // empty text against a star-only pattern
    send_word(OP_END, 8'h00);
    // star then any-one
    send_word(OP_APPEND, CH_ANY);
    send_word(OP_TEXT, CH_A);
    send_word(OP_END, 8'h00);
    // append in mid-text abandons the text; empty text then misses
    send_word(OP_APPEND, CH_B);
    send_word(OP_TEXT, 8'h78);
    send_word(OP_APPEND, 8'h63);
    send_word(OP_END, 8'h00);

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 9) == 0) noise_burst();
      else glob_session();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_owed != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (verdicts_owed != 0) $error("%0d expected results never arrived", verdicts_owed);
    if (fail_count == 0 && verdicts_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
hdl/wpm_pkg.sv
hdl/wildcard_pattern_matcher.sv
sim/wpm_match_checker.sv
sim/wildcard_pattern_matcher_test.sv
